>>> hw/rtl/cmsa_pkg.sv
package cmsa_pkg;

   // command codes
   localparam logic [2:0] CMD_MEM_READ    = 3'd0;
   localparam logic [2:0] CMD_MEM_WRITE   = 3'd1;
   localparam logic [2:0] CMD_STACK_READ  = 3'd2;
   localparam logic [2:0] CMD_STACK_WRITE = 3'd3;
   localparam logic [2:0] CMD_PUSH        = 3'd4;
   localparam logic [2:0] CMD_POP         = 3'd5;
   localparam logic [2:0] CMD_IMAGE_LOAD  = 3'd6;

   // access size codes; any other code is a four-byte access
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OUT_MEM   = 3'd1;
   localparam logic [2:0] ST_ROM_WRITE = 3'd2;
   localparam logic [2:0] ST_OUT_STACK = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;
   localparam logic [2:0] ST_UNDERFLOW = 3'd5;

   // register indexes (word address paddr[3:2])
   localparam logic [1:0] REG_MEM_END   = 2'd0;
   localparam logic [1:0] REG_RAM_START = 2'd1;
   localparam logic [1:0] REG_STACK_END = 2'd2;

   // register reset values
   localparam logic [20:0] MEM_END_RST   = 21'h100000;
   localparam logic [20:0] RAM_START_RST = 21'h000000;
   localparam logic [16:0] STACK_END_RST = 17'h10000;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [1:0]  access_size;
      logic [31:0] address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  status;
      logic [16:0] stack_pointer;
   } rsp_type;

endpackage

>>> hw/rtl/cmsa_ram.sv
module cmsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/checked_memory_stack_access_unit.sv
// Sequence: an accepted command runs the checks and the byte-bank access in the access
// state, then the registered bank read in the data state; the result strobe and beat are
// loaded as the data state ends, and the receiver cannot stall them. busy is high only in
// the access state, so the next command is taken in the data state, while the result
// register is being loaded.
// Reset (synchronous): clears the stack pointer, the control state and sets the bound
// registers to their defaults; memory contents are undefined until written, no clearing.
module checked_memory_stack_access_unit
   import cmsa_pkg::*;
#(
   parameter int MEM_BYTES   = 1048576,
   parameter int STACK_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   // result channel
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int MEM_ROWS = (MEM_BYTES + 3) / 4;
   localparam int STK_ROWS = (STACK_BYTES + 3) / 4;
   localparam int MROW_W   = $clog2(MEM_ROWS);
   localparam int SROW_W   = $clog2(STK_ROWS);
   localparam int SP_W     = $clog2(STACK_BYTES + 1);
   localparam logic [33:0] MEM_CAP = 34'(MEM_BYTES);
   localparam logic [33:0] STK_CAP = 34'(STACK_BYTES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACCESS,
      S_DATA
   } state_type;

   state_type         state_ff;
   req_type           req_ff;
   logic [SP_W-1:0]   stack_ptr_ff, stack_ptr_in;
   logic [20:0]       mem_end_ff, ram_start_ff;
   logic [16:0]       stack_end_ff;
   logic              rsp_strobe_ff;
   rsp_type           rsp_ff;

   // access phase results held for the data phase
   logic [2:0]        status_ff, status_in;
   logic              rd_main_ff, rd_main_in;
   logic              rd_stack_ff, rd_stack_in;
   logic [1:0]        ea_lo_ff;
   logic [2:0]        len_ff;

   logic              req_accept;
   logic              cfg_write;
   logic              main_wr, stack_wr;
   logic [2:0]        len;
   logic [31:0]       ea;
   logic [33:0]       ea_end;
   logic [33:0]       mend, send;
   logic              main_ok, stk_ok, push_ok, pop_bad;
   logic [3:0][7:0]   aligned;
   logic [1:0]        off_acc [4];
   logic [1:0]        off_dat [4];
   logic [MROW_W-1:0] main_row [4];
   logic [SROW_W-1:0] stk_row [4];
   logic [7:0]        wr_byte [4];
   logic              byte_on [4];
   logic              main_we [4];
   logic              stk_we [4];
   logic [7:0]        main_q [4];
   logic [7:0]        stk_q [4];
   logic [3:0][7:0]   rd_raw;
   logic [31:0]       rd_value;

   assign busy       = (state_ff == S_ACCESS);
   assign req_accept = start & ~busy;
   assign pready     = 1'b1;
   assign cfg_write  = psel & penable & pwrite & pready;

   // register port
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_end_ff   <= MEM_END_RST;
         ram_start_ff <= RAM_START_RST;
         stack_end_ff <= STACK_END_RST;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            REG_MEM_END:   mem_end_ff   <= pwdata[20:0];
            REG_RAM_START: ram_start_ff <= pwdata[20:0];
            REG_STACK_END: stack_end_ff <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_MEM_END:   prdata = 32'(mem_end_ff);
         REG_RAM_START: prdata = 32'(ram_start_ff);
         REG_STACK_END: prdata = 32'(stack_end_ff);
         default:       prdata = 32'd0;
      endcase
   end

   // effective bounds, saturated to the store sizes
   assign mend = (34'(mem_end_ff) < MEM_CAP) ? 34'(mem_end_ff) : MEM_CAP;
   assign send = (34'(stack_end_ff) < STK_CAP) ? 34'(stack_end_ff) : STK_CAP;

   // command beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_payload;
      end
   end

   // access length; push and pop are always four bytes
   always_comb begin
      if (req_ff.cmd == CMD_PUSH || req_ff.cmd == CMD_POP) begin
         len = 3'd4;
      end else begin
         unique case (req_ff.access_size)
            SIZE_BYTE: len = 3'd1;
            SIZE_HALF: len = 3'd2;
            default:   len = 3'd4;
         endcase
      end
   end

   // effective byte address
   always_comb begin
      unique case (req_ff.cmd)
         CMD_PUSH: ea = 32'(stack_ptr_ff);
         CMD_POP:  ea = 32'(stack_ptr_ff - SP_W'(4));
         default:  ea = req_ff.address;
      endcase
   end

   // bound checks
   assign ea_end  = 34'(req_ff.address) + 34'(len);
   assign main_ok = (ea_end <= mend);
   assign stk_ok  = (ea_end <= send);
   assign push_ok = (34'(stack_ptr_ff) + 34'd4 <= send);
   assign pop_bad = (stack_ptr_ff < SP_W'(4)) || (34'(stack_ptr_ff) > STK_CAP);

   // decide status and the side effects
   always_comb begin
      status_in    = ST_OK;
      rd_main_in   = 1'b0;
      rd_stack_in  = 1'b0;
      main_wr      = 1'b0;
      stack_wr     = 1'b0;
      stack_ptr_in = stack_ptr_ff;
      unique case (req_ff.cmd)
         CMD_MEM_READ: begin
            if (!main_ok) status_in = ST_OUT_MEM;
            else          rd_main_in = 1'b1;
         end
         CMD_MEM_WRITE: begin
            if (!main_ok)                                   status_in = ST_OUT_MEM;
            else if (req_ff.address < 32'(ram_start_ff))    status_in = ST_ROM_WRITE;
            else                                            main_wr = 1'b1;
         end
         CMD_IMAGE_LOAD: begin
            if (!main_ok) status_in = ST_OUT_MEM;
            else          main_wr = 1'b1;
         end
         CMD_STACK_READ: begin
            if (!stk_ok) status_in = ST_OUT_STACK;
            else         rd_stack_in = 1'b1;
         end
         CMD_STACK_WRITE: begin
            if (!stk_ok) status_in = ST_OUT_STACK;
            else         stack_wr = 1'b1;
         end
         CMD_PUSH: begin
            if (!push_ok) begin
               status_in = ST_OVERFLOW;
            end else begin
               stack_wr     = 1'b1;
               stack_ptr_in = stack_ptr_ff + SP_W'(4);
            end
         end
         CMD_POP: begin
            if (pop_bad) begin
               status_in = ST_UNDERFLOW;
            end else begin
               rd_stack_in  = 1'b1;
               stack_ptr_in = stack_ptr_ff - SP_W'(4);
            end
         end
         default: ;
      endcase
   end

   // write data left aligned: byte 0 of the access sits in the top lane
   always_comb begin
      unique case (len)
         3'd1:    aligned = {req_ff.write_data[7:0], 24'd0};
         3'd2:    aligned = {req_ff.write_data[15:0], 16'd0};
         default: aligned = req_ff.write_data;
      endcase
   end

   // per-bank row, byte and enable; bank k holds bytes with address mod 4 == k
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         off_acc[k]  = 2'(k) - ea[1:0];
         byte_on[k]  = ({1'b0, off_acc[k]} < len);
         main_row[k] = ea[MROW_W+1:2] + MROW_W'(2'(k) < ea[1:0]);
         stk_row[k]  = ea[SROW_W+1:2] + SROW_W'(2'(k) < ea[1:0]);
         // lane 3 - off is ~off for two bits
         wr_byte[k]  = aligned[~off_acc[k]];
         main_we[k]  = (state_ff == S_ACCESS) && main_wr && byte_on[k];
         stk_we[k]   = (state_ff == S_ACCESS) && stack_wr && byte_on[k];
      end
   end

   // byte banks
   for (genvar g = 0; g < 4; g++) begin : g_bank
      cmsa_ram #(
         .WIDTH (8),
         .DEPTH (MEM_ROWS)
      ) u_main (
         .clock   (clock),
         .wr_en   (main_we[g]),
         .addr    (main_row[g]),
         .wr_data (wr_byte[g]),
         .rd_data (main_q[g])
      );

      cmsa_ram #(
         .WIDTH (8),
         .DEPTH (STK_ROWS)
      ) u_stack (
         .clock   (clock),
         .wr_en   (stk_we[g]),
         .addr    (stk_row[g]),
         .wr_data (wr_byte[g]),
         .rd_data (stk_q[g])
      );
   end

   // access phase info for the data phase
   always_ff @(posedge clock) begin
      if (state_ff == S_ACCESS) begin
         status_ff   <= status_in;
         rd_main_ff  <= rd_main_in;
         rd_stack_ff <= rd_stack_in;
         ea_lo_ff    <= ea[1:0];
         len_ff      <= len;
      end
   end

   // gather bank outputs back into big-endian order
   always_comb begin
      rd_raw = '0;
      for (int k = 0; k < 4; k++) begin
         off_dat[k]          = 2'(k) - ea_lo_ff;
         rd_raw[~off_dat[k]] = rd_main_ff ? main_q[k] : stk_q[k];
      end
      if (!(rd_main_ff || rd_stack_ff)) begin
         rd_value = 32'd0;
      end else begin
         unique case (len_ff)
            3'd1:    rd_value = {24'd0, rd_raw[3]};
            3'd2:    rd_value = {16'd0, rd_raw[3], rd_raw[2]};
            default: rd_value = rd_raw;
         endcase
      end
   end

   // sequencer, stack pointer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         stack_ptr_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) state_ff <= S_ACCESS;
            end
            S_ACCESS: begin
               state_ff     <= S_DATA;
               stack_ptr_ff <= stack_ptr_in;
            end
            S_DATA: begin
               rsp_strobe_ff               <= 1'b1;
               rsp_ff.read_data            <= rd_value;
               rsp_ff.status               <= status_ff;
               rsp_ff.stack_pointer        <= 17'(stack_ptr_ff);
               state_ff                    <= req_accept ? S_ACCESS : S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // a result beat only follows a data phase
   a_rsp_after_data: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_DATA))
      else $error("result beat without a data phase");

   // an accepted command always runs its access phase next
   a_accept_access: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy)
      else $error("accepted command did not enter the access phase");

   // the stack pointer moves only on a push or pop in the access phase
   a_sp_moves: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(stack_ptr_ff)) |->
         ($past(state_ff == S_ACCESS) &&
          ($past(req_ff.cmd) == CMD_PUSH || $past(req_ff.cmd) == CMD_POP)))
      else $error("stack pointer changed outside push or pop");

   // a flagged access returns no data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status != ST_OK) |-> (rsp_payload.read_data == 32'd0))
      else $error("flagged access returned data");
`endif

endmodule
